@@ design/circle_from_three_points_defines.svh @@
// ----------------------------------------------------------------------------
// circle_from_three_points assertion macros
// Shared assertion forms for the circumcircle datapath. Expects clk_i and
// rst_ni in the scope of use.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_FROM_THREE_POINTS_DEFINES_SVH
`define CIRCLE_FROM_THREE_POINTS_DEFINES_SVH

// same-cycle implication
`define CFTP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cftp: same-cycle check failed");

// next-cycle implication
`define CFTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cftp: next-cycle check failed");

`endif

@@ design/cftp_pkg.sv @@
// ----------------------------------------------------------------------------
// cftp_pkg
// Output format constants and carried types for the circumcircle pipeline.
// ----------------------------------------------------------------------------
package cftp_pkg;

  localparam int unsigned OUT_BITS = 24;
  localparam int unsigned RAD_BITS = 2 * OUT_BITS;   // radicand kept after range check
  localparam int unsigned DM_W     = 31;             // offset magnitude kept for squaring
  localparam int unsigned SQ_W     = 2 * DM_W;
  localparam int unsigned RSQ_W    = SQ_W + 1;

  localparam logic signed [OUT_BITS-1:0] CTR_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] CTR_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
  localparam logic [OUT_BITS-1:0]        RAD_MAX = {OUT_BITS{1'b1}};
  localparam logic [31:0]                DMAG_LIM = 32'h8000_0000;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] cx;
    logic signed [OUT_BITS-1:0] cy;
    logic                       scx;
    logic                       scy;
    logic                       zero;
  } ctr_t;

  typedef struct packed {
    logic [RAD_BITS-1:0] rem;
    logic [OUT_BITS-1:0] root;
    logic                rsat;
    ctr_t                c;
  } sq_t;

endpackage

@@ design/circle_from_three_points.sv @@
// ----------------------------------------------------------------------------
// circle_from_three_points
// Pipelined circumcircle: exact integer numerators and denominator, bit-per-
// stage restoring divide for the centre, bit-per-stage square root for radius.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  in      | in_valid_i / in_ready_o    | point{1,2,3}_{x,y}_i
//  out     | out_valid_o / out_ready_i  | center_x_o center_y_o radius_o
//          |                            | degenerate_o
//
//  One request per cycle unless the output stalls. Most stages form the
//  divider (one quotient bit per stage over OUT_BITS + FRAC_BITS stages)
//  and the square root (one root bit per stage over OUT_BITS stages).
//  Reset clears the valid chain only. While a result waits at the output,
//  the whole pipeline holds and in_ready_o is low.
// ----------------------------------------------------------------------------
`include "circle_from_three_points_defines.svh"

module circle_from_three_points #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [COORD_BITS-1:0]                point1_x_i,
  input  logic [COORD_BITS-1:0]                point1_y_i,
  input  logic [COORD_BITS-1:0]                point2_x_i,
  input  logic [COORD_BITS-1:0]                point2_y_i,
  input  logic [COORD_BITS-1:0]                point3_x_i,
  input  logic [COORD_BITS-1:0]                point3_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [cftp_pkg::OUT_BITS-1:0] center_x_o,
  output logic signed [cftp_pkg::OUT_BITS-1:0] center_y_o,
  output logic [cftp_pkg::OUT_BITS-1:0]        radius_o,
  output logic                                 degenerate_o
);
  import cftp_pkg::*;

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned OB   = OUT_BITS;
  localparam int unsigned DFW  = C + 1;
  localparam int unsigned PRW  = 2 * C + 1;
  localparam int unsigned SQW  = 2 * C + 1;
  localparam int unsigned CRW  = 2 * C + 2;
  localparam int unsigned DW   = 2 * C + 3;
  localparam int unsigned PW   = 3 * C + 2;
  localparam int unsigned NXW  = 3 * C + 4;
  localparam int unsigned NW   = (NXW > OB + 1) ? NXW : OB + 1;
  localparam int unsigned QB   = OB + FRAC_BITS;
  localparam int unsigned DDW  = NW + FRAC_BITS;
  localparam int unsigned DXW  = ((OB > C + FRAC_BITS) ? OB : C + FRAC_BITS) + 2;
  localparam int unsigned SW   = 2 * OB + 1;
  localparam int unsigned NST  = QB + OB + 14;
  localparam int unsigned DIV_END = 6 + QB;
  localparam int unsigned SQ_END  = 12 + QB + OB;

  typedef struct packed {
    logic [DW-1:0] rx;
    logic [DW-1:0] ry;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
    logic [QB-1:0] lx;
    logic [QB-1:0] ly;
    logic [DW-1:0] d;
    logic          negx;
    logic          negy;
    logic          psx;
    logic          psy;
    logic          zero;
    logic [C-1:0]  x1;
    logic [C-1:0]  y1;
  } div_t;

  function automatic logic [OB:0] sat_centre(input logic [QB:0] fx, input logic neg,
                                             input logic presat);
    logic [OB:0] res;
    if (presat) begin
      res = {1'b1, (neg ? CTR_MIN : CTR_MAX)};
    end else if (!neg && (fx > (QB+1)'(CTR_MAX))) begin
      res = {1'b1, CTR_MAX};
    end else if (neg && (fx > ((QB+1)'(1) << (OB - 1)))) begin
      res = {1'b1, CTR_MIN};
    end else if (neg) begin
      res = {1'b0, ~fx[OB-1:0] + OB'(1)};
    end else begin
      res = {1'b0, fx[OB-1:0]};
    end
    return res;
  endfunction

  logic           adv;
  logic [NST-1:0] vld_q;

  assign adv         = ~vld_q[NST-1] | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // stage A: request capture
  logic [C-1:0] a_px_q [3];
  logic [C-1:0] a_py_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_px_q[0] <= point1_x_i;
      a_py_q[0] <= point1_y_i;
      a_px_q[1] <= point2_x_i;
      a_py_q[1] <= point2_y_i;
      a_px_q[2] <= point3_x_i;
      a_py_q[2] <= point3_y_i;
    end
  end

  // stage B: differences, squares, cross products
  logic signed [DFW-1:0] b_dx_d [3];
  logic signed [DFW-1:0] b_dy_d [3];
  logic signed [DFW-1:0] b_dx_q [3];
  logic signed [DFW-1:0] b_dy_q [3];
  logic [2*C-1:0]        b_xx_q [3];
  logic [2*C-1:0]        b_yy_q [3];
  logic signed [PRW-1:0] b_pa_q, b_pb_q;
  logic [C-1:0]          b_x1_q, b_y1_q;

  always_comb begin
    b_dy_d[0] = $signed({1'b0, a_py_q[1]}) - $signed({1'b0, a_py_q[2]});
    b_dy_d[1] = $signed({1'b0, a_py_q[2]}) - $signed({1'b0, a_py_q[0]});
    b_dy_d[2] = $signed({1'b0, a_py_q[0]}) - $signed({1'b0, a_py_q[1]});
    b_dx_d[0] = $signed({1'b0, a_px_q[2]}) - $signed({1'b0, a_px_q[1]});
    b_dx_d[1] = $signed({1'b0, a_px_q[0]}) - $signed({1'b0, a_px_q[2]});
    b_dx_d[2] = $signed({1'b0, a_px_q[1]}) - $signed({1'b0, a_px_q[0]});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_dx_q[i] <= b_dx_d[i];
        b_dy_q[i] <= b_dy_d[i];
        b_xx_q[i] <= a_px_q[i] * a_px_q[i];
        b_yy_q[i] <= a_py_q[i] * a_py_q[i];
      end
      // (x2-x1)(y3-y1) and (y2-y1)(x3-x1)
      b_pa_q <= b_dx_d[2] * b_dy_d[1];
      b_pb_q <= b_dy_d[2] * b_dx_d[1];
      b_x1_q <= a_px_q[0];
      b_y1_q <= a_py_q[0];
    end
  end

  // stage C: squared norms and cross term
  logic [SQW-1:0]        c_s_q  [3];
  logic signed [DFW-1:0] c_dx_q [3];
  logic signed [DFW-1:0] c_dy_q [3];
  logic signed [CRW-1:0] c_cr_q;
  logic [C-1:0]          c_x1_q, c_y1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c_s_q[i]  <= SQW'(b_xx_q[i]) + SQW'(b_yy_q[i]);
        c_dx_q[i] <= b_dx_q[i];
        c_dy_q[i] <= b_dy_q[i];
      end
      c_cr_q <= CRW'(b_pa_q) - CRW'(b_pb_q);
      c_x1_q <= b_x1_q;
      c_y1_q <= b_y1_q;
    end
  end

  // stage D: numerator partial products
  logic signed [PW-1:0] d_mx_q [3];
  logic signed [PW-1:0] d_my_q [3];
  logic signed [DW-1:0] d_den_q;
  logic [C-1:0]         d_x1_q, d_y1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_mx_q[i] <= $signed({1'b0, c_s_q[i]}) * c_dy_q[i];
        d_my_q[i] <= $signed({1'b0, c_s_q[i]}) * c_dx_q[i];
      end
      d_den_q <= DW'(c_cr_q) <<< 1;
      d_x1_q  <= c_x1_q;
      d_y1_q  <= c_y1_q;
    end
  end

  // stage E: numerators
  logic signed [NXW-1:0] e_nx_q, e_ny_q;
  logic signed [DW-1:0]  e_den_q;
  logic [C-1:0]          e_x1_q, e_y1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_nx_q  <= NXW'(d_mx_q[0]) + NXW'(d_mx_q[1]) + NXW'(d_mx_q[2]);
      e_ny_q  <= NXW'(d_my_q[0]) + NXW'(d_my_q[1]) + NXW'(d_my_q[2]);
      e_den_q <= d_den_q;
      e_x1_q  <= d_x1_q;
      e_y1_q  <= d_y1_q;
    end
  end

  // stage F: sign and magnitude
  logic [NXW-1:0] f_nmx_q, f_nmy_q;
  logic [DW-1:0]  f_dm_q;
  logic           f_negx_q, f_negy_q, f_zero_q;
  logic [C-1:0]   f_x1_q, f_y1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_nmx_q  <= e_nx_q[NXW-1] ? NXW'(-e_nx_q) : NXW'(e_nx_q);
      f_nmy_q  <= e_ny_q[NXW-1] ? NXW'(-e_ny_q) : NXW'(e_ny_q);
      f_dm_q   <= e_den_q[DW-1] ? DW'(-e_den_q) : DW'(e_den_q);
      f_negx_q <= e_nx_q[NXW-1] ^ e_den_q[DW-1];
      f_negy_q <= e_ny_q[NXW-1] ^ e_den_q[DW-1];
      f_zero_q <= (e_den_q == '0);
      f_x1_q   <= e_x1_q;
      f_y1_q   <= e_y1_q;
    end
  end

  // stage G: range check on the integer quotient, divider load
  logic [DDW-1:0]   g_ddx, g_ddy;
  logic [DW+OB-1:0] g_dsh;
  div_t             g_ld;
  div_t             div_q [QB+1];

  always_comb begin
    g_ddx = DDW'(f_nmx_q) << FRAC_BITS;
    g_ddy = DDW'(f_nmy_q) << FRAC_BITS;
    g_dsh = (DW+OB)'(f_dm_q) << OB;
    g_ld.rx   = DW'(g_ddx[DDW-1:QB]);
    g_ld.ry   = DW'(g_ddy[DDW-1:QB]);
    g_ld.qx   = '0;
    g_ld.qy   = '0;
    g_ld.lx   = g_ddx[QB-1:0];
    g_ld.ly   = g_ddy[QB-1:0];
    g_ld.d    = f_dm_q;
    g_ld.negx = f_negx_q;
    g_ld.negy = f_negy_q;
    g_ld.psx  = (f_nmx_q >= g_dsh);
    g_ld.psy  = (f_nmy_q >= g_dsh);
    g_ld.zero = f_zero_q;
    g_ld.x1   = f_x1_q;
    g_ld.y1   = f_y1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= g_ld;
    end
  end

  // restoring divide, one quotient bit per stage for both lanes
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DW:0] tx, ty;
    logic        gex, gey;
    div_t        nxt;

    always_comb begin
      tx  = {div_q[k].rx, div_q[k].lx[QB-1]};
      ty  = {div_q[k].ry, div_q[k].ly[QB-1]};
      gex = (tx >= {1'b0, div_q[k].d});
      gey = (ty >= {1'b0, div_q[k].d});
      nxt    = div_q[k];
      nxt.rx = gex ? DW'(tx - {1'b0, div_q[k].d}) : DW'(tx);
      nxt.ry = gey ? DW'(ty - {1'b0, div_q[k].d}) : DW'(ty);
      nxt.qx = {div_q[k].qx[QB-2:0], gex};
      nxt.qy = {div_q[k].qy[QB-2:0], gey};
      nxt.lx = div_q[k].lx << 1;
      nxt.ly = div_q[k].ly << 1;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k+1] <= nxt;
      end
    end
  end

  // stage H: round half away from zero on the magnitude
  logic [QB:0]  h_fxx_q, h_fxy_q;
  logic         h_negx_q, h_negy_q, h_psx_q, h_psy_q, h_zero_q;
  logic [C-1:0] h_x1_q, h_y1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_fxx_q  <= {1'b0, div_q[QB].qx} +
                  (QB+1)'({div_q[QB].rx, 1'b0} >= {1'b0, div_q[QB].d});
      h_fxy_q  <= {1'b0, div_q[QB].qy} +
                  (QB+1)'({div_q[QB].ry, 1'b0} >= {1'b0, div_q[QB].d});
      h_negx_q <= div_q[QB].negx;
      h_negy_q <= div_q[QB].negy;
      h_psx_q  <= div_q[QB].psx;
      h_psy_q  <= div_q[QB].psy;
      h_zero_q <= div_q[QB].zero;
      h_x1_q   <= div_q[QB].x1;
      h_y1_q   <= div_q[QB].y1;
    end
  end

  // stage I: signed, saturated centre
  logic [OB:0]  i_rx, i_ry;
  ctr_t         i_c_q;
  logic [C-1:0] i_x1_q, i_y1_q;

  always_comb begin
    i_rx = sat_centre(h_fxx_q, h_negx_q, h_psx_q);
    i_ry = sat_centre(h_fxy_q, h_negy_q, h_psy_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      i_c_q.cx   <= i_rx[OB-1:0];
      i_c_q.scx  <= i_rx[OB];
      i_c_q.cy   <= i_ry[OB-1:0];
      i_c_q.scy  <= i_ry[OB];
      i_c_q.zero <= h_zero_q;
      i_x1_q     <= h_x1_q;
      i_y1_q     <= h_y1_q;
    end
  end

  // stage J: offset of the rounded centre from the first point
  logic signed [DXW-1:0] j_dx_q, j_dy_q;
  ctr_t                  j_c_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      j_dx_q <= DXW'(i_c_q.cx) - $signed(DXW'(i_x1_q) << FRAC_BITS);
      j_dy_q <= DXW'(i_c_q.cy) - $signed(DXW'(i_y1_q) << FRAC_BITS);
      j_c_q  <= i_c_q;
    end
  end

  // stage K: magnitudes and radius range check
  logic [DXW-1:0]  k_ax, k_ay;
  logic [DM_W-1:0] k_ax_q, k_ay_q;
  logic            k_big_q;
  ctr_t            k_c_q;

  always_comb begin
    k_ax = j_dx_q[DXW-1] ? DXW'(-j_dx_q) : DXW'(j_dx_q);
    k_ay = j_dy_q[DXW-1] ? DXW'(-j_dy_q) : DXW'(j_dy_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_ax_q  <= DM_W'(k_ax);
      k_ay_q  <= DM_W'(k_ay);
      k_big_q <= (k_ax >= DMAG_LIM) | (k_ay >= DMAG_LIM);
      k_c_q   <= j_c_q;
    end
  end

  // stage L: squares
  logic [SQ_W-1:0] l_sx_q, l_sy_q;
  logic            l_big_q;
  ctr_t            l_c_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_sx_q  <= k_ax_q * k_ax_q;
      l_sy_q  <= k_ay_q * k_ay_q;
      l_big_q <= k_big_q;
      l_c_q   <= k_c_q;
    end
  end

  // stage M: radicand, square root load
  logic [RSQ_W-1:0] m_v;
  sq_t              m_ld;
  sq_t              sq_q [OB+1];

  always_comb begin
    m_v       = RSQ_W'(l_sx_q) + RSQ_W'(l_sy_q);
    m_ld.rem  = m_v[RAD_BITS-1:0];
    m_ld.root = '0;
    m_ld.rsat = l_big_q | (m_v >= (RSQ_W'(1) << RAD_BITS));
    m_ld.c    = l_c_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0] <= m_ld;
    end
  end

  // square root, one root bit per stage, remainder kept as v - root^2
  for (genvar k = 0; k < OB; k++) begin : g_sqrt
    localparam int unsigned BI = OB - 1 - k;
    logic [SW-1:0] trial;
    logic          ge;
    sq_t           nxt;

    always_comb begin
      trial = (SW'(sq_q[k].root) << (BI + 1)) | (SW'(1) << (2 * BI));
      ge    = (SW'(sq_q[k].rem) >= trial);
      nxt   = sq_q[k];
      if (ge) begin
        nxt.rem  = RAD_BITS'(SW'(sq_q[k].rem) - trial);
        nxt.root = sq_q[k].root | (OB'(1) << BI);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k+1] <= nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (sq_q[OB].c.zero) begin
        center_x_o   <= '0;
        center_y_o   <= '0;
        radius_o     <= '0;
        degenerate_o <= 1'b1;
      end else begin
        center_x_o   <= sq_q[OB].c.cx;
        center_y_o   <= sq_q[OB].c.cy;
        radius_o     <= sq_q[OB].rsat ? RAD_MAX : sq_q[OB].root;
        degenerate_o <= sq_q[OB].c.scx | sq_q[OB].c.scy | sq_q[OB].rsat;
      end
    end
  end

  // divider leaves a remainder below the divisor whenever the quotient was in range
  `CFTP_ASSERT_NOW(a_div_rem_x, vld_q[DIV_END] && !div_q[QB].zero && !div_q[QB].psx, div_q[QB].rx < div_q[QB].d)
  `CFTP_ASSERT_NOW(a_div_rem_y, vld_q[DIV_END] && !div_q[QB].zero && !div_q[QB].psy, div_q[QB].ry < div_q[QB].d)
  // truncated root: v - r^2 never exceeds 2r
  `CFTP_ASSERT_NOW(a_sqrt_rem, vld_q[SQ_END] && !sq_q[OB].rsat, sq_q[OB].rem <= RAD_BITS'({sq_q[OB].root, 1'b0}))
  `CFTP_ASSERT_NEXT(a_out_fill, adv && vld_q[NST-2], out_valid_o)

endmodule

@@ sim/circle_from_three_points_test.sv @@
// ----------------------------------------------------------------------------
// circle_from_three_points_test
// Drives point triples through the circumcircle pipeline with random idling
// on both channels and checks every result against an in-bench predictor.
// ----------------------------------------------------------------------------
module circle_from_three_points_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cftp_pkg::*;

  localparam int unsigned CB  = 12;
  localparam int unsigned FB  = 8;
  localparam int unsigned LAT = FB + 62;
  localparam longint      CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CB-1:0] x1, y1, x2, y2, x3, y3;
  } triple_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] cx;
    logic signed [OUT_BITS-1:0] cy;
    logic [OUT_BITS-1:0]        rad;
    logic                       degen;
  } circle_t;

  class circle_board;
    circle_t pending[$];
    int      errors;

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // rounded quotient with FB fraction bits, ties away from zero
    function longint centre_div(longint num, longint den, ref bit sat);
      longint unsigned n, d, q, r, fx;
      bit neg;
      longint res;
      n = mag(num);
      d = mag(den);
      neg = (num < 0) != (den < 0);
      q = n / d;
      r = n % d;
      if (q >= (64'd1 << OUT_BITS)) begin
        sat = 1;
        return neg ? longint'(CTR_MIN) : longint'(CTR_MAX);
      end
      fx = q;
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        fx = fx << 1;
        if (r >= d) begin
          r = r - d;
          fx = fx | 1;
        end
      end
      if (2 * r >= d) fx = fx + 1;
      res = neg ? -longint'(fx) : longint'(fx);
      if (res > longint'(CTR_MAX)) begin sat = 1; res = CTR_MAX; end
      if (res < longint'(CTR_MIN)) begin sat = 1; res = CTR_MIN; end
      return res;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    function void note_request(triple_t t);
      longint x1, y1, x2, y2, x3, y3, s1, s2, s3, den, nx, ny, cx, cy, dx, dy;
      longint unsigned rad;
      bit sat;
      circle_t c;
      x1 = t.x1; y1 = t.y1; x2 = t.x2; y2 = t.y2; x3 = t.x3; y3 = t.y3;
      sat = 0;
      s1 = x1 * x1 + y1 * y1;
      s2 = x2 * x2 + y2 * y2;
      s3 = x3 * x3 + y3 * y3;
      den = 2 * (x1 * (y2 - y3) - y1 * (x2 - x3) + x2 * y3 - x3 * y2);
      if (den == 0) begin
        c = '{cx: '0, cy: '0, rad: '0, degen: 1'b1};
      end else begin
        nx = s1 * (y2 - y3) + s2 * (y3 - y1) + s3 * (y1 - y2);
        ny = s1 * (x3 - x2) + s2 * (x1 - x3) + s3 * (x2 - x1);
        cx = centre_div(nx, den, sat);
        cy = centre_div(ny, den, sat);
        dx = cx - (x1 << FB);
        dy = cy - (y1 << FB);
        if (mag(dx) >= (64'd1 << 31) || mag(dy) >= (64'd1 << 31)) begin
          rad = RAD_MAX;
          sat = 1;
        end else begin
          rad = root_floor(mag(dx) * mag(dx) + mag(dy) * mag(dy));
          if (rad > RAD_MAX) begin rad = RAD_MAX; sat = 1; end
        end
        c.cx = cx[OUT_BITS-1:0];
        c.cy = cy[OUT_BITS-1:0];
        c.rad = rad[OUT_BITS-1:0];
        c.degen = sat;
      end
      pending = {pending, c};
    endfunction

    function void check_circle(circle_t got);
      circle_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result cx=%0d cy=%0d r=%0d d=%0b", $time,
                 got.cx, got.cy, got.rad, got.degen);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.cx !== e.cx) begin
        $display("%0t: center_x exp %0d got %0d", $time, e.cx, got.cx);
        errors++;
      end
      if (got.cy !== e.cy) begin
        $display("%0t: center_y exp %0d got %0d", $time, e.cy, got.cy);
        errors++;
      end
      if (got.rad !== e.rad) begin
        $display("%0t: radius exp %0d got %0d", $time, e.rad, got.rad);
        errors++;
      end
      if (got.degen !== e.degen) begin
        $display("%0t: degenerate exp %0b got %0b", $time, e.degen, got.degen);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [CB-1:0] p1x, p1y, p2x, p2y, p3x, p3y;
  logic signed [OUT_BITS-1:0] center_x_o, center_y_o;
  logic [OUT_BITS-1:0] radius_o;
  logic degenerate_o;

  circle_board board;
  bit     quiet;     // no idling in the closing stretch
  longint cycles;

  circle_from_three_points #(.COORD_BITS(CB), .FRAC_BITS(FB)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .point1_x_i(p1x), .point1_y_i(p1y), .point2_x_i(p2x),
    .point2_y_i(p2y), .point3_x_i(p3x), .point3_y_i(p3y),
    .out_valid_o, .out_ready_i, .center_x_o, .center_y_o, .radius_o,
    .degenerate_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("circle_from_three_points_test: errors");
        $finish;
      end
    end
  end

  // result side: random stall bursts, check on each accepted result
  initial begin
    int gap;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        board.check_circle('{cx: center_x_o, cy: center_y_o, rad: radius_o,
                             degen: degenerate_o});
      if (gap > 0) begin
        gap--;
        out_ready_i <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 9) - 1;
        out_ready_i <= 0;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  task automatic send_request(triple_t t);
    p1x <= t.x1; p1y <= t.y1; p2x <= t.x2;
    p2y <= t.y2; p3x <= t.x3; p3y <= t.y3;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(t);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  function automatic logic [CB-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CB'($urandom_range(0, 15));
      3: return CB'(4095 - $urandom_range(0, 15));
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic triple_t rnd_triple();
    triple_t t;
    t = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
    case ($urandom_range(0, 9))
      0: begin t.x2 = t.x1; t.y2 = t.y1; end           // repeated point
      1: begin t.x3 = t.x1; t.x2 = t.x1; end           // vertical line
      2: begin                                          // nearly collinear
        t.x2 = CB'($urandom_range(0, 2047));
        t.y2 = CB'($urandom_range(0, 2047));
        t.x1 = t.x2 + t.x2 / 2 + CB'($urandom_range(0, 1));
        t.y1 = t.y2 + t.y2 / 2;
        t.x3 = 0; t.y3 = 0;
      end
      default: ;
    endcase
    return t;
  endfunction

  initial begin
    triple_t t;
    board = new();
    quiet = 0;
    rst_ni = 0;
    in_valid_i = 0;
    {p1x, p1y, p2x, p2y, p3x, p3y} = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, collinear and coincident, saturating centres
    send_request('{0, 0, 4095, 0, 0, 4095});
    send_request('{4095, 4095, 0, 4095, 4095, 0});
    send_request('{0, 0, 0, 0, 0, 0});
    send_request('{4095, 4095, 4095, 4095, 4095, 4095});
    send_request('{0, 0, 1, 1, 2, 2});
    send_request('{5, 7, 5, 7, 100, 3});
    send_request('{0, 0, 1, 0, 0, 1});
    send_request('{0, 0, 4095, 1, 2048, 1});
    send_request('{0, 0, 4095, 0, 2048, 1});
    send_request('{0, 4095, 4095, 4094, 2048, 4094});
    send_request('{0, 0, 4094, 2047, 4095, 2048});
    send_request('{0, 0, 4095, 2048, 4094, 2047});
    send_request('{10, 10, 20, 10, 15, 18});
    send_request('{1, 0, 0, 1, 4095, 4095});
    send_request('{2048, 0, 0, 2048, 4095, 2048});
    send_request('{4095, 0, 0, 0, 1, 4095});
    send_request('{0, 1, 1, 0, 2, 1});
    send_request('{3000, 3001, 3002, 3003, 3004, 3006});
    send_request('{2730, 1365, 1365, 2730, 0, 4095});

    // hold off until the pipe has drained
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);

    for (int n = 0; n < 1100; n++) begin
      if (n == 950) quiet = 1;
      if (n == 500) begin
        in_valid_i <= 0;
        while (board.pending.size() != 0) @(posedge clk_i);
      end
      send_request(rnd_triple());
    end
    in_valid_i <= 0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
    if (board.errors == 0)
      $display("circle_from_three_points_test: clean");
    else
      $display("circle_from_three_points_test: errors");
    $finish;
  end

endmodule
